// ===== design/lfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lfp_pkg: shared types and constants of the line follower PID controller
// Register map, reset values, stage and gain bundles, sensor pattern decode.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_GAIN_P     = 3'd0;
  localparam logic [2:0] REG_GAIN_D     = 3'd1;
  localparam logic [2:0] REG_GAIN_I     = 3'd2;
  localparam logic [2:0] REG_BASE_SPEED = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED  = 3'd4;

  localparam logic [7:0] GAIN_P_RESET     = 8'd30;
  localparam logic [7:0] GAIN_D_RESET     = 8'd5;
  localparam logic [7:0] GAIN_I_RESET     = 8'd0;
  localparam logic [7:0] BASE_SPEED_RESET = 8'd150;
  localparam logic [7:0] MAX_SPEED_RESET  = 8'd255;

  localparam logic signed [16:0] SUM_MAX = 17'sd32767;
  localparam logic signed [16:0] SUM_MIN = -17'sd32768;

  typedef struct packed {
    logic [7:0] gain_p;
    logic [7:0] gain_d;
    logic [7:0] gain_i;
    logic [7:0] base_speed;
    logic [7:0] max_speed;
  } gains_t;

  typedef struct packed {
    logic signed [3:0]  err;
    logic signed [4:0]  diff;
    logic signed [15:0] sum;
  } stage_t;

  typedef struct packed {
    logic              hit;
    logic signed [3:0] err;
  } map_t;

  function automatic map_t map_error(input logic [4:0] pattern);
    map_t m;
    m.hit = 1'b1;
    m.err = 4'sd0;
    unique case (pattern)
      5'b10000: m.err = 4'sd4;
      5'b11000: m.err = 4'sd3;
      5'b01000: m.err = 4'sd2;
      5'b01100: m.err = 4'sd1;
      5'b00100: m.err = 4'sd0;
      5'b00110: m.err = -4'sd1;
      5'b00010: m.err = -4'sd2;
      5'b00011: m.err = -4'sd3;
      5'b00001: m.err = -4'sd4;
      default:  m.hit = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/lfp_drive.sv =====
// ----------------------------------------------------------------------------
// lfp_drive: PID term and clamped drive values
// Forms the weighted sum of error, error change and error sum, then the
// clamped left and right drive values around the base speed.
// ----------------------------------------------------------------------------
module lfp_drive (
  input  lfp_pkg::gains_t   gains,
  input  lfp_pkg::stage_t   stage,
  output logic signed [8:0] left_drive,
  output logic signed [8:0] right_drive
);

  logic signed [8:0]  gp_s;
  logic signed [8:0]  gd_s;
  logic signed [8:0]  gi_s;
  logic signed [8:0]  base_s;
  logic signed [8:0]  lim_pos;
  logic signed [9:0]  lim_neg;
  logic signed [12:0] p_term;
  logic signed [13:0] d_term;
  logic signed [24:0] i_term;
  logic signed [26:0] term;
  logic signed [27:0] left_raw;
  logic signed [27:0] right_raw;
  logic signed [27:0] left_clamped;
  logic signed [27:0] right_clamped;

  assign gp_s    = {1'b0, gains.gain_p};
  assign gd_s    = {1'b0, gains.gain_d};
  assign gi_s    = {1'b0, gains.gain_i};
  assign base_s  = {1'b0, gains.base_speed};
  assign lim_pos = {1'b0, gains.max_speed};
  assign lim_neg = -$signed({2'b00, gains.max_speed});

  assign p_term = 13'(gp_s) * 13'(stage.err);
  assign d_term = 14'(gd_s) * 14'(stage.diff);
  assign i_term = 25'(gi_s) * 25'(stage.sum);
  assign term   = 27'(p_term) + 27'(d_term) + 27'(i_term);

  assign left_raw  = 28'(base_s) + 28'(term);
  assign right_raw = 28'(base_s) - 28'(term);

  always_comb begin
    priority if (left_raw > lim_pos) begin
      left_clamped = 28'(lim_pos);
    end else if (left_raw < lim_neg) begin
      left_clamped = 28'(lim_neg);
    end else begin
      left_clamped = left_raw;
    end
    priority if (right_raw > lim_pos) begin
      right_clamped = 28'(lim_pos);
    end else if (right_raw < lim_neg) begin
      right_clamped = 28'(lim_neg);
    end else begin
      right_clamped = right_raw;
    end
  end

  assign left_drive  = left_clamped[8:0];
  assign right_drive = right_clamped[8:0];

endmodule

// ===== design/line_follower_pid.sv =====
// Path: an accepted transaction is registered in the stage register, then in the output register that raises out_valid.
// Throughput: one transaction per cycle while the output is not stalled; the error state updates at accept.
// Reset: gains and speeds return to their defaults, error and error sum clear,
// and both pipeline stages empty.
// ----------------------------------------------------------------------------
// line_follower_pid: five-sensor line follower PID controller
// Maps a sensor sample to a position error and produces clamped drive values.
// ----------------------------------------------------------------------------
module line_follower_pid (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [4:0]                  line_sensors,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [8:0]           left_drive,
  output logic signed [8:0]           right_drive,
  output logic signed [3:0]           line_error,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfp_pkg::ADDR_W-1:0]  paddr,
  input  logic [lfp_pkg::DATA_W-1:0]  pwdata,
  output logic [lfp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  lfp_pkg::gains_t   gains;
  logic [2:0]        reg_idx;
  logic              cfg_write;

  logic signed [3:0]  last_error;
  logic signed [15:0] error_sum;
  lfp_pkg::map_t      mapped;
  logic signed [3:0]  err_next;
  logic signed [16:0] sum_wide;
  logic signed [15:0] error_sum_next;
  lfp_pkg::stage_t    stage_next;

  lfp_pkg::stage_t    stage;
  logic               stage_valid;
  logic               stage_adv;
  logic               in_accept;
  logic signed [8:0]  left_calc;
  logic signed [8:0]  right_calc;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.gain_p     <= lfp_pkg::GAIN_P_RESET;
      gains.gain_d     <= lfp_pkg::GAIN_D_RESET;
      gains.gain_i     <= lfp_pkg::GAIN_I_RESET;
      gains.base_speed <= lfp_pkg::BASE_SPEED_RESET;
      gains.max_speed  <= lfp_pkg::MAX_SPEED_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        lfp_pkg::REG_GAIN_P:     gains.gain_p     <= pwdata[7:0];
        lfp_pkg::REG_GAIN_D:     gains.gain_d     <= pwdata[7:0];
        lfp_pkg::REG_GAIN_I:     gains.gain_i     <= pwdata[7:0];
        lfp_pkg::REG_BASE_SPEED: gains.base_speed <= pwdata[7:0];
        lfp_pkg::REG_MAX_SPEED:  gains.max_speed  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lfp_pkg::REG_GAIN_P:     prdata = {24'd0, gains.gain_p};
      lfp_pkg::REG_GAIN_D:     prdata = {24'd0, gains.gain_d};
      lfp_pkg::REG_GAIN_I:     prdata = {24'd0, gains.gain_i};
      lfp_pkg::REG_BASE_SPEED: prdata = {24'd0, gains.base_speed};
      lfp_pkg::REG_MAX_SPEED:  prdata = {24'd0, gains.max_speed};
      default:                 prdata = '0;
    endcase
  end

  // advance when the next stage is empty or drains this cycle
  assign stage_adv = !out_valid || !out_stall;
  assign in_stall  = stage_valid && !stage_adv;
  assign in_accept = in_valid && !in_stall;

  assign mapped   = lfp_pkg::map_error(line_sensors);
  assign err_next = mapped.hit ? mapped.err : last_error;
  assign sum_wide = 17'(error_sum) + 17'(err_next);

  always_comb begin
    priority if (sum_wide > lfp_pkg::SUM_MAX) begin
      error_sum_next = lfp_pkg::SUM_MAX[15:0];
    end else if (sum_wide < lfp_pkg::SUM_MIN) begin
      error_sum_next = lfp_pkg::SUM_MIN[15:0];
    end else begin
      error_sum_next = sum_wide[15:0];
    end
  end

  always_comb begin
    stage_next.err  = err_next;
    stage_next.diff = 5'(err_next) - 5'(last_error);
    stage_next.sum  = error_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error  <= '0;
      error_sum   <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        last_error <= err_next;
        error_sum  <= error_sum_next;
      end
      if (in_accept) begin
        stage_valid <= 1'b1;
      end else if (stage_adv) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage <= stage_next;
    end
  end

  lfp_drive u_drive (
    .gains       (gains),
    .stage       (stage),
    .left_drive  (left_calc),
    .right_drive (right_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage_valid) begin
      left_drive  <= left_calc;
      right_drive <= right_calc;
      line_error  <= stage.err;
    end
  end

`ifndef SYNTH
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_error >= -4'sd4 && line_error <= 4'sd4))
    else $error("line_error out of range");

  a_left_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed({1'b0, left_drive[8] ? -left_drive : left_drive})
                   <= $signed({2'b00, gains.max_speed})))
    else $error("left_drive exceeds max_speed");

  a_hold_unmapped: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !mapped.hit) |=> (last_error == $past(last_error)))
    else $error("unmapped pattern changed last_error");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && out_valid && out_stall) |-> in_stall)
    else $error("stage overwritten while output stalled");
`endif

endmodule
